### sv/vdpr_pkg.sv
package vdpr_pkg;

    // fixed field widths
    localparam int VRAM_ADDR_W = 13;
    localparam int CFG_INDEX_W = 2;
    localparam int CFG_DATA_W  = 8;

    // configuration register indexes
    localparam logic [CFG_INDEX_W-1:0] REG_X_OFFSET = 2'd0;
    localparam logic [CFG_INDEX_W-1:0] REG_Y_OFFSET = 2'd1;

    // configuration reset values
    localparam logic [7:0] X_OFFSET_RESET = 8'd8;
    localparam logic [7:0] Y_OFFSET_RESET = 8'd0;

    // rgb565 colours
    localparam logic [15:0] COLOR_BLACK  = 16'h0000;
    localparam logic [15:0] COLOR_WHITE  = 16'hFFFF;
    localparam logic [15:0] COLOR_BAND_A = 16'h07E0;
    localparam logic [15:0] COLOR_BAND_B = 16'h001F;

    // colour band limits on the panel row, column limits before offset
    localparam logic [15:0] BAND_A_LO = 16'(24 + 240 / 256);
    localparam logic [15:0] BAND_A_HI = 16'(56 * 240 / 256);
    localparam logic [15:0] BAND_B_LO = 16'(176 * 240 / 256);
    localparam logic [15:0] BAND_B_HI = 16'(232 * 240 / 256);
    localparam logic [7:0]  BASE_COL_LO = 8'd16;
    localparam logic [7:0]  BASE_COL_HI = 8'd134;

    // depth of the queue between front and back
    localparam int QUEUE_DEPTH = 2;

    // live configuration
    typedef struct packed {
        logic [7:0] x_offset;
        logic [7:0] y_offset;
    } vdpr_cfg_t;

    // one classified byte write, handed from front to back
    typedef struct packed {
        logic [7:0]  pixel_x;
        logic [7:0]  col;
        logic [15:0] base_row;
        logic [7:0]  keep;
        logic [7:0]  new_byte;
    } vdpr_job_t;

endpackage

### sv/vdpr_in_if.sv
interface vdpr_in_if
    import vdpr_pkg::*;
;
    logic                   valid;
    logic                   ready;
    logic [VRAM_ADDR_W-1:0] vram_address;
    logic [7:0]             vram_byte;

    modport source (output valid, output vram_address, output vram_byte, input ready);
    modport sink (input valid, input vram_address, input vram_byte, output ready);
endinterface

### sv/vdpr_out_if.sv
interface vdpr_out_if
    import vdpr_pkg::*;
;
    logic        valid;
    logic        ready;
    logic [7:0]  pixel_x;
    logic [7:0]  pixel_y;
    logic [15:0] pixel_color;
    logic        last_pixel;

    modport source (output valid, output pixel_x, output pixel_y, output pixel_color,
                    output last_pixel, input ready);
    modport sink (input valid, input pixel_x, input pixel_y, input pixel_color,
                  input last_pixel, output ready);
endinterface

### sv/video_ram_delta_pixel_renderer_unit.sv
// throughput: one byte write per cycle at the front unless the pipeline stalls or clears,
//   one pixel per cycle at the output while the port is ready; a write paints 0 to 8 pixels
// reset: offsets return to 8 and 0; the shadow copy is cleared one byte per cycle,
//   and no write is taken until the clearing is done
module video_ram_delta_pixel_renderer_unit
    import vdpr_pkg::*;
#(
    parameter int LINE_BYTES     = 32,
    parameter int SOURCE_HEIGHT  = 256,
    parameter int SOURCE_COLUMNS = 224,
    parameter int PANEL_SIZE     = 240
)
(
    input  logic                   clk,
    input  logic                   rst_n,
    input  logic                   cfg_we,
    input  logic [CFG_INDEX_W-1:0] cfg_index,
    input  logic [CFG_DATA_W-1:0]  cfg_data,
    vdpr_in_if.sink                vram_wr,
    vdpr_out_if.source             pixel_wr
);

    vdpr_cfg_t  cfg_reg;
    vdpr_cfg_t  cfg_next;

    logic       front_valid;
    logic       front_ready;
    vdpr_job_t  front_job;
    logic       back_valid;
    logic       back_ready;
    vdpr_job_t  back_job;

    // configuration registers
    always_comb
    begin
        cfg_next = cfg_reg;
        if (cfg_we)
        begin
            case (cfg_index)
                REG_X_OFFSET: cfg_next.x_offset = cfg_data;
                REG_Y_OFFSET: cfg_next.y_offset = cfg_data;
                default:      cfg_next = cfg_reg;
            endcase
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            cfg_reg.x_offset <= X_OFFSET_RESET;
            cfg_reg.y_offset <= Y_OFFSET_RESET;
        end
        else
        begin
            cfg_reg <= cfg_next;
        end
    end

    // front: shadow compare and classification
    vdpr_front #(
        .LINE_BYTES     (LINE_BYTES),
        .SOURCE_HEIGHT  (SOURCE_HEIGHT),
        .SOURCE_COLUMNS (SOURCE_COLUMNS),
        .PANEL_SIZE     (PANEL_SIZE)
    ) u_front (
        .clk       (clk),
        .rst_n     (rst_n),
        .cfg       (cfg_reg),
        .vram_wr   (vram_wr),
        .job_valid (front_valid),
        .job_ready (front_ready),
        .job       (front_job)
    );

    // queue between front and back
    vdpr_queue u_queue (
        .clk        (clk),
        .rst_n      (rst_n),
        .push_valid (front_valid),
        .push_ready (front_ready),
        .push_data  (front_job),
        .pop_valid  (back_valid),
        .pop_ready  (back_ready),
        .pop_data   (back_job)
    );

    // back: one pixel per cycle while the output port is ready
    vdpr_back u_back (
        .clk       (clk),
        .rst_n     (rst_n),
        .cfg       (cfg_reg),
        .job_valid (back_valid),
        .job_ready (back_ready),
        .job       (back_job),
        .pixel_wr  (pixel_wr)
    );

endmodule

### sv/vdpr_queue.sv
module vdpr_queue
    import vdpr_pkg::*;
(
    input  logic      clk,
    input  logic      rst_n,
    input  logic      push_valid,
    output logic      push_ready,
    input  vdpr_job_t push_data,
    output logic      pop_valid,
    input  logic      pop_ready,
    output vdpr_job_t pop_data
);

    localparam int PTR_W = (QUEUE_DEPTH > 1) ? $clog2(QUEUE_DEPTH) : 1;
    localparam int CNT_W = $clog2(QUEUE_DEPTH + 1);

    vdpr_job_t          slot_reg [QUEUE_DEPTH];
    logic [PTR_W-1:0]   wr_ptr_reg;
    logic [PTR_W-1:0]   wr_ptr_next;
    logic [PTR_W-1:0]   rd_ptr_reg;
    logic [PTR_W-1:0]   rd_ptr_next;
    logic [CNT_W-1:0]   count_reg;
    logic [CNT_W-1:0]   count_next;
    logic               do_push;
    logic               do_pop;

    // handshake
    assign push_ready = (count_reg != CNT_W'(QUEUE_DEPTH));
    assign pop_valid  = (count_reg != '0);
    assign pop_data   = slot_reg[rd_ptr_reg];
    assign do_push    = push_valid && push_ready;
    assign do_pop     = pop_valid && pop_ready;

    // pointer and fill count update
    always_comb
    begin
        wr_ptr_next = wr_ptr_reg;
        rd_ptr_next = rd_ptr_reg;
        count_next  = count_reg;
        if (do_push)
        begin
            wr_ptr_next = (wr_ptr_reg == PTR_W'(QUEUE_DEPTH - 1)) ? '0 : wr_ptr_reg + 1'b1;
        end
        if (do_pop)
        begin
            rd_ptr_next = (rd_ptr_reg == PTR_W'(QUEUE_DEPTH - 1)) ? '0 : rd_ptr_reg + 1'b1;
        end
        if (do_push && !do_pop)
        begin
            count_next = count_reg + 1'b1;
        end
        else if (do_pop && !do_push)
        begin
            count_next = count_reg - 1'b1;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            count_reg  <= '0;
        end
        else
        begin
            wr_ptr_reg <= wr_ptr_next;
            rd_ptr_reg <= rd_ptr_next;
            count_reg  <= count_next;
        end
    end

    // slot storage
    always_ff @(posedge clk)
    begin
        if (do_push)
        begin
            slot_reg[wr_ptr_reg] <= push_data;
        end
    end

endmodule

### sv/vdpr_front.sv
module vdpr_front
    import vdpr_pkg::*;
#(
    parameter int LINE_BYTES     = 32,
    parameter int SOURCE_HEIGHT  = 256,
    parameter int SOURCE_COLUMNS = 224,
    parameter int PANEL_SIZE     = 240
)
(
    input  logic       clk,
    input  logic       rst_n,
    input  vdpr_cfg_t  cfg,
    vdpr_in_if.sink    vram_wr,
    output logic       job_valid,
    input  logic       job_ready,
    output vdpr_job_t  job
);

    localparam int SHADOW_DEPTH = SOURCE_COLUMNS * LINE_BYTES;
    localparam int IDX_W        = (SHADOW_DEPTH > 1) ? $clog2(SHADOW_DEPTH) : 1;
    localparam int REM_W        = (LINE_BYTES > 1) ? $clog2(LINE_BYTES) : 1;
    localparam int ADDR_W       = VRAM_ADDR_W;
    // reciprocal of the line length, exact for every address of ADDR_W bits
    localparam int RECIP_SH     = ADDR_W + $clog2(LINE_BYTES);
    localparam int RECIP_M      = ((1 << RECIP_SH) + LINE_BYTES - 1) / LINE_BYTES;
    localparam int PROD_W       = 2 * ADDR_W + 1;

    localparam logic [ADDR_W:0]   RECIP_C  = (ADDR_W + 1)'(RECIP_M);
    localparam logic [ADDR_W-1:0] LINE_C   = ADDR_W'(LINE_BYTES);
    localparam logic [8:0]        PANEL_X_C = 9'(PANEL_SIZE);
    localparam logic [15:0]       PANEL_Y_C = 16'(PANEL_SIZE);
    localparam logic [IDX_W-1:0]  CLR_LAST_C = IDX_W'(SHADOW_DEPTH - 1);

    // shadow copy of video memory
    logic [7:0]         shadow_mem [SHADOW_DEPTH];
    logic [7:0]         rd_data_reg;
    logic               mem_we;
    logic [IDX_W-1:0]   mem_wr_idx;
    logic [7:0]         mem_wr_data;

    // clearing pass after reset
    logic               clr_active_reg;
    logic               clr_active_next;
    logic [IDX_W-1:0]   clr_idx_reg;
    logic [IDX_W-1:0]   clr_idx_next;

    // last write, for a read that met a write to the same byte
    logic               fwd_valid_reg;
    logic               fwd_valid_next;
    logic [IDX_W-1:0]   fwd_idx_reg;
    logic [7:0]         fwd_byte_reg;

    // stage 1: shadow read resolved, column split
    logic               accept;
    logic               s1_valid_reg;
    logic               s1_valid_next;
    logic [ADDR_W-1:0]  s1_addr_reg;
    logic [7:0]         s1_byte_reg;
    logic               s1_adv;
    logic               s1_ok;
    logic [IDX_W-1:0]   s1_idx;
    logic [7:0]         s1_old;
    logic [7:0]         s1_diff;
    logic [PROD_W-1:0]  s1_prod;

    // stage 2: row index, column position
    logic               s2_valid_reg;
    logic               s2_valid_next;
    logic [ADDR_W-1:0]  s2_addr_reg;
    logic [ADDR_W-1:0]  s2_q_reg;
    logic [7:0]         s2_diff_reg;
    logic [7:0]         s2_byte_reg;
    logic               s2_adv;
    logic [ADDR_W-1:0]  s2_rem_full;
    logic [REM_W-1:0]   s2_rem;
    logic [15:0]        s2_base;
    logic [8:0]         s2_px;
    logic [15:0]        base_tab [LINE_BYTES];

    // stage 3: on-panel mask, hand-off to the queue
    logic               s3_valid_reg;
    logic               s3_valid_next;
    logic [8:0]         s3_px_reg;
    logic [7:0]         s3_col_reg;
    logic [15:0]        s3_base_reg;
    logic [7:0]         s3_diff_reg;
    logic [7:0]         s3_byte_reg;
    logic               s3_adv;
    logic [7:0]         s3_keep;

    // base row for each byte within a source column
    for (genvar g = 0; g < LINE_BYTES; g++)
    begin : g_base
        localparam int BASE_V = ((SOURCE_HEIGHT - g * 8) - 8) * PANEL_SIZE / SOURCE_HEIGHT;
        assign base_tab[g] = 16'(BASE_V);
    end

    // input handshake
    assign vram_wr.ready = !clr_active_reg && (!s1_valid_reg || s1_adv);
    assign accept        = vram_wr.valid && vram_wr.ready;

    // stage 1 logic
    assign s1_adv  = s1_valid_reg && (!s2_valid_reg || s2_adv);
    assign s1_ok   = (int'(s1_addr_reg) < SHADOW_DEPTH);
    assign s1_idx  = IDX_W'(s1_addr_reg);
    assign s1_old  = (fwd_valid_reg && (fwd_idx_reg == s1_idx)) ? fwd_byte_reg : rd_data_reg;
    assign s1_diff = s1_ok ? (s1_old ^ s1_byte_reg) : 8'd0;
    assign s1_prod = PROD_W'({1'b0, s1_addr_reg} * RECIP_C);

    // shadow write port: clearing pass or the byte leaving stage 1
    always_comb
    begin
        if (clr_active_reg)
        begin
            mem_we      = 1'b1;
            mem_wr_idx  = clr_idx_reg;
            mem_wr_data = 8'd0;
        end
        else
        begin
            mem_we      = s1_adv && s1_ok;
            mem_wr_idx  = s1_idx;
            mem_wr_data = s1_byte_reg;
        end
    end

    always_ff @(posedge clk)
    begin
        if (mem_we)
        begin
            shadow_mem[mem_wr_idx] <= mem_wr_data;
        end
    end

    always_ff @(posedge clk)
    begin
        if (accept)
        begin
            rd_data_reg <= shadow_mem[IDX_W'(vram_wr.vram_address)];
        end
    end

    // stage 2 logic
    assign s2_adv      = s2_valid_reg && (!s3_valid_reg || s3_adv);
    assign s2_rem_full = s2_addr_reg - s2_q_reg * LINE_C;
    assign s2_rem      = s2_rem_full[REM_W-1:0];
    assign s2_base     = base_tab[s2_rem];
    assign s2_px       = {1'b0, s2_q_reg[7:0]} + {1'b0, cfg.x_offset};

    // stage 3 logic: a changed bit whose pixel lands on the panel
    always_comb
    begin
        logic [15:0] row_i;
        logic [15:0] py_i;
        for (int i = 0; i < 8; i++)
        begin
            row_i      = s3_base_reg - 16'(i);
            py_i       = row_i + {8'd0, cfg.y_offset};
            s3_keep[i] = s3_diff_reg[i] && (s3_px_reg < PANEL_X_C) && (py_i < PANEL_Y_C);
        end
    end

    assign s3_adv       = s3_valid_reg && ((s3_keep == 8'd0) || job_ready);
    assign job_valid    = s3_valid_reg && (s3_keep != 8'd0);
    assign job.pixel_x  = s3_px_reg[7:0];
    assign job.col      = s3_col_reg;
    assign job.base_row = s3_base_reg;
    assign job.keep     = s3_keep;
    assign job.new_byte = s3_byte_reg;

    // control next state
    always_comb
    begin
        clr_active_next = clr_active_reg;
        clr_idx_next    = clr_idx_reg;
        if (clr_active_reg)
        begin
            clr_idx_next = clr_idx_reg + 1'b1;
            if (clr_idx_reg == CLR_LAST_C)
            begin
                clr_active_next = 1'b0;
            end
        end

        fwd_valid_next = fwd_valid_reg || (!clr_active_reg && mem_we);

        s1_valid_next = accept ? 1'b1 : (s1_adv ? 1'b0 : s1_valid_reg);
        s2_valid_next = s1_adv ? 1'b1 : (s2_adv ? 1'b0 : s2_valid_reg);
        s3_valid_next = s2_adv ? 1'b1 : (s3_adv ? 1'b0 : s3_valid_reg);
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            clr_active_reg <= 1'b1;
            clr_idx_reg    <= '0;
            fwd_valid_reg  <= 1'b0;
            s1_valid_reg   <= 1'b0;
            s2_valid_reg   <= 1'b0;
            s3_valid_reg   <= 1'b0;
        end
        else
        begin
            clr_active_reg <= clr_active_next;
            clr_idx_reg    <= clr_idx_next;
            fwd_valid_reg  <= fwd_valid_next;
            s1_valid_reg   <= s1_valid_next;
            s2_valid_reg   <= s2_valid_next;
            s3_valid_reg   <= s3_valid_next;
        end
    end

    // payload registers
    always_ff @(posedge clk)
    begin
        if (!clr_active_reg && mem_we)
        begin
            fwd_idx_reg  <= s1_idx;
            fwd_byte_reg <= s1_byte_reg;
        end
        if (accept)
        begin
            s1_addr_reg <= vram_wr.vram_address;
            s1_byte_reg <= vram_wr.vram_byte;
        end
        if (s1_adv)
        begin
            s2_addr_reg <= s1_addr_reg;
            s2_q_reg    <= ADDR_W'(s1_prod >> RECIP_SH);
            s2_diff_reg <= s1_diff;
            s2_byte_reg <= s1_byte_reg;
        end
        if (s2_adv)
        begin
            s3_px_reg   <= s2_px;
            s3_col_reg  <= s2_q_reg[7:0];
            s3_base_reg <= s2_base;
            s3_diff_reg <= s2_diff_reg;
            s3_byte_reg <= s2_byte_reg;
        end
    end

    // reciprocal split leaves a remainder inside one source column
    assert property (@(posedge clk) disable iff (!rst_n)
        s2_valid_reg |-> (s2_rem_full < LINE_C))
        else $error("column split remainder out of range");

    // nothing enters the pipeline while the shadow copy is being cleared
    assert property (@(posedge clk) disable iff (!rst_n)
        clr_active_reg |-> (!s1_valid_reg && !s2_valid_reg && !s3_valid_reg))
        else $error("request in flight during clearing pass");

    // the forwarded byte is the one stage 1 just wrote
    assert property (@(posedge clk) disable iff (!rst_n)
        (!clr_active_reg && mem_we) |=> (fwd_valid_reg && fwd_byte_reg == $past(s1_byte_reg)))
        else $error("forwarding register missed a shadow write");

endmodule

### sv/vdpr_back.sv
module vdpr_back
    import vdpr_pkg::*;
(
    input  logic       clk,
    input  logic       rst_n,
    input  vdpr_cfg_t  cfg,
    input  logic       job_valid,
    output logic       job_ready,
    input  vdpr_job_t  job,
    vdpr_out_if.source pixel_wr
);

    vdpr_job_t    cur_reg;
    logic [7:0]   mask_reg;
    logic [7:0]   mask_next;
    logic         out_valid_reg;
    logic         out_valid_next;
    logic [7:0]   out_x_reg;
    logic [7:0]   out_y_reg;
    logic [15:0]  out_color_reg;
    logic         out_last_reg;

    logic         busy;
    logic         can_emit;
    logic         pop;
    logic [2:0]   bit_idx;
    logic [7:0]   mask_rest;
    logic         emit_last;
    logic [15:0]  row;
    logic [7:0]   py;
    logic [15:0]  color;

    // lowest pixel still to paint
    always_comb
    begin
        bit_idx = 3'd0;
        for (int i = 7; i >= 0; i--)
        begin
            if (mask_reg[i])
            begin
                bit_idx = 3'(i);
            end
        end
    end

    assign busy      = (mask_reg != 8'd0);
    assign can_emit  = busy && (!out_valid_reg || pixel_wr.ready);
    assign mask_rest = mask_reg & ~(8'd1 << bit_idx);
    assign emit_last = (mask_rest == 8'd0);
    assign job_ready = !busy || (can_emit && emit_last);
    assign pop       = job_valid && job_ready;

    // row, panel row and colour of the current pixel
    assign row = cur_reg.base_row - {13'd0, bit_idx};
    assign py  = row[7:0] + cfg.y_offset;

    always_comb
    begin
        if (!cur_reg.new_byte[bit_idx])
        begin
            color = COLOR_BLACK;
        end
        else if (row > BAND_A_LO && row <= BAND_A_HI)
        begin
            color = COLOR_BAND_A;
        end
        else if (row > BAND_B_LO && row <= BAND_B_HI)
        begin
            color = COLOR_BAND_B;
        end
        else if (row > BAND_B_HI && cur_reg.col >= BASE_COL_LO && cur_reg.col < BASE_COL_HI)
        begin
            color = COLOR_BAND_B;
        end
        else
        begin
            color = COLOR_WHITE;
        end
    end

    // control next state
    always_comb
    begin
        if (pop)
        begin
            mask_next = job.keep;
        end
        else if (can_emit)
        begin
            mask_next = mask_rest;
        end
        else
        begin
            mask_next = mask_reg;
        end
        out_valid_next = can_emit ? 1'b1 : (pixel_wr.ready ? 1'b0 : out_valid_reg);
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            mask_reg      <= 8'd0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            mask_reg      <= mask_next;
            out_valid_reg <= out_valid_next;
        end
    end

    // payload registers
    always_ff @(posedge clk)
    begin
        if (pop)
        begin
            cur_reg <= job;
        end
        if (can_emit)
        begin
            out_x_reg     <= cur_reg.pixel_x;
            out_y_reg     <= py;
            out_color_reg <= color;
            out_last_reg  <= emit_last;
        end
    end

    assign pixel_wr.valid       = out_valid_reg;
    assign pixel_wr.pixel_x     = out_x_reg;
    assign pixel_wr.pixel_y     = out_y_reg;
    assign pixel_wr.pixel_color = out_color_reg;
    assign pixel_wr.last_pixel  = out_last_reg;

    // pending pixels of one request only ever drop away
    assert property (@(posedge clk) disable iff (!rst_n)
        (busy && !pop) |=> ((mask_reg & ~$past(mask_reg)) == 8'd0))
        else $error("pixel mask gained a bit");

    // the queue never hands over a request with nothing to paint
    assert property (@(posedge clk) disable iff (!rst_n)
        pop |=> (mask_reg != 8'd0))
        else $error("empty request taken from queue");

    // a pixel shown as last leaves nothing behind of its request
    assert property (@(posedge clk) disable iff (!rst_n)
        (can_emit && emit_last && !pop) |=> !busy)
        else $error("pixels left after last pixel");

endmodule
